// ----- sv/msort_pkg.sv -----
// Shared types and constants for the merge sorter.
`timescale 1ns / 1ps

package msort_pkg;

   localparam int MAX_ITEMS_DEF = 64;
   localparam int DATA_W        = 32;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     final_item;
   } req_beat_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     final_result;
      logic                     overflowed;
   } rsp_beat_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic prime;
      logic merge;
      logic next_pair;
      logic emit_start;
      logic emit_read;
      logic emit_load;
      logic clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sorted;
      logic pair_last;
      logic out_final;
   } status_type;

endpackage

// ----- sv/msort_ctrl.sv -----
// Controller state machine of the merge sorter.
`timescale 1ns / 1ps

module msort_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_final,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  msort_pkg::status_type status,
   output msort_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_LOAD      = 8'b0000_0001,
      ST_CHECK     = 8'b0000_0010,
      ST_PRIME     = 8'b0000_0100,
      ST_MERGE     = 8'b0000_1000,
      ST_NEXT      = 8'b0001_0000,
      ST_EMIT_RD   = 8'b0010_0000,
      ST_EMIT_LD   = 8'b0100_0000,
      ST_EMIT_WAIT = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_final) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // The run width has reached the element count once the store is sorted.
            if (status.sorted) begin
               cmd.emit_start = 1'b1;
               state_in       = ST_EMIT_RD;
            end else begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            cmd.prime = 1'b1;
            state_in  = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            if (status.pair_last) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            cmd.next_pair = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_EMIT_RD: begin
            cmd.emit_read = 1'b1;
            state_in      = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            cmd.emit_load = 1'b1;
            state_in      = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_ready) begin
               if (status.out_final) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_LOAD;
               end else begin
                  cmd.emit_read = 1'b1;
                  state_in      = ST_EMIT_LD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_EMIT_WAIT);

endmodule

// ----- sv/msort_dp.sv -----
// Datapath of the merge sorter: two element banks, merge pointers and result register.
`timescale 1ns / 1ps

module msort_dp #(
   parameter int MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic signed [msort_pkg::DATA_W-1:0] req_value,
   input  msort_pkg::cmd_type             cmd,
   output msort_pkg::status_type          status,
   output msort_pkg::rsp_beat_type        rsp_beat
);

   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int AW = $clog2(MAX_ITEMS);
   localparam int WW = CW + 2;

   logic signed [msort_pkg::DATA_W-1:0] mem0 [MAX_ITEMS];
   logic signed [msort_pkg::DATA_W-1:0] mem1 [MAX_ITEMS];

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [WW-1:0] width_ff, width_in;
   logic [WW-1:0] lo_ff, lo_in;
   logic [WW-1:0] mid_ff, mid_in;
   logic [WW-1:0] hi_ff, hi_in;
   logic [WW-1:0] i_ff, i_in;
   logic [WW-1:0] j_ff, j_in;
   logic [WW-1:0] k_ff, k_in;
   logic          src_ff, src_in;
   logic signed [msort_pkg::DATA_W-1:0] rd_a_ff, rd_b_ff;
   msort_pkg::rsp_beat_type rsp_ff, rsp_in;

   logic [WW-1:0] n_w;
   logic [WW-1:0] lo_w, lo_2w, mid_new, hi_new;
   logic [WW-1:0] rd_a_addr, rd_b_addr;
   logic          take_a;
   logic          room;
   logic signed [msort_pkg::DATA_W-1:0] wr_data;
   logic          wr0_en, wr1_en;
   logic [AW-1:0] wr0_addr;
   logic signed [msort_pkg::DATA_W-1:0] wr0_data;

   assign n_w     = {{(WW-CW){1'b0}}, count_ff};
   assign room    = (count_ff < CW'(MAX_ITEMS));
   assign lo_w    = lo_ff + width_ff;
   assign lo_2w   = lo_ff + {width_ff[WW-2:0], 1'b0};
   assign mid_new = (lo_w < n_w) ? lo_w : n_w;
   assign hi_new  = (lo_2w < n_w) ? lo_2w : n_w;

   // Stable merge: the left run wins ties.
   assign take_a  = (i_ff < mid_ff) && ((j_ff >= hi_ff) || !(rd_b_ff < rd_a_ff));
   assign wr_data = take_a ? rd_a_ff : rd_b_ff;

   always_comb begin
      rd_a_addr = i_ff;
      rd_b_addr = j_ff;
      if (cmd.prime) begin
         rd_a_addr = lo_ff;
         rd_b_addr = mid_new;
      end else if (cmd.merge) begin
         // Fetch the new head of whichever run just gave up its element.
         rd_a_addr = take_a ? (i_ff + WW'(1)) : i_ff;
         rd_b_addr = take_a ? j_ff : (j_ff + WW'(1));
      end else if (cmd.emit_read) begin
         rd_a_addr = k_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      width_in = width_ff;
      lo_in    = lo_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      src_in   = src_ff;
      rsp_in   = rsp_ff;
      if (cmd.load) begin
         if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
         width_in = WW'(1);
         lo_in    = '0;
         src_in   = 1'b0;
      end
      if (cmd.prime) begin
         mid_in = mid_new;
         hi_in  = hi_new;
         i_in   = lo_ff;
         j_in   = mid_new;
         k_in   = lo_ff;
      end
      if (cmd.merge) begin
         i_in = take_a ? (i_ff + WW'(1)) : i_ff;
         j_in = take_a ? j_ff : (j_ff + WW'(1));
         k_in = k_ff + WW'(1);
      end
      if (cmd.next_pair) begin
         if (lo_2w >= n_w) begin
            lo_in    = '0;
            width_in = {width_ff[WW-2:0], 1'b0};
            src_in   = ~src_ff;
         end else begin
            lo_in = lo_2w;
         end
      end
      if (cmd.emit_start) begin
         k_in = '0;
      end
      if (cmd.emit_load) begin
         rsp_in.sorted_value = rd_a_ff;
         rsp_in.final_result = ((k_ff + WW'(1)) == n_w);
         rsp_in.overflowed   = ovf_ff;
         k_in                = k_ff + WW'(1);
      end
      if (cmd.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         src_ff   <= 1'b0;
         width_ff <= WW'(1);
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         src_ff   <= src_in;
         width_ff <= width_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      rsp_ff <= rsp_in;
   end

   // Bank 0 takes loaded elements and the output of the passes that read bank 1.
   assign wr0_en   = (cmd.load && room) || (cmd.merge && src_ff);
   assign wr0_addr = cmd.load ? count_ff[AW-1:0] : k_ff[AW-1:0];
   assign wr0_data = cmd.load ? req_value : wr_data;
   assign wr1_en   = cmd.merge && !src_ff;

   always_ff @(posedge clock) begin
      if (wr0_en) begin
         mem0[wr0_addr] <= wr0_data;
      end
      if (wr1_en) begin
         mem1[k_ff[AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (src_ff) begin
         rd_a_ff <= mem1[rd_a_addr[AW-1:0]];
         rd_b_ff <= mem1[rd_b_addr[AW-1:0]];
      end else begin
         rd_a_ff <= mem0[rd_a_addr[AW-1:0]];
         rd_b_ff <= mem0[rd_b_addr[AW-1:0]];
      end
   end

   assign status.sorted    = (width_ff >= n_w);
   assign status.pair_last = ((k_ff + WW'(1)) == hi_ff);
   assign status.out_final = rsp_ff.final_result;
   assign rsp_beat         = rsp_ff;

endmodule

// ----- sv/merge_sorter.sv -----
// Top level of the merge sorter: stable ascending sort of a signed 32-bit list.
//
//   Channel   Dir   Handshake              Beat
//   req_      in    req_valid/req_ready    value, final_item
//   rsp_      out   rsp_valid/rsp_ready    sorted_value, final_result, overflowed
//
// Loading takes one cycle per beat; beats past MAX_ITEMS are dropped and flagged.
// Sorting is a bottom-up merge between two banks: ceil(log2 n) passes, in which
// each run pair goes through check, prime, merge and next, one merge step per cycle.
// Emission reads each result from the bank, then loads it into the result register;
// each later read is issued as the result before it is accepted, the first in a read state of its own.
// Reset clears the element count, the overflow flag and the controller.
// A stalled result holds; no new list is taken until the final result is accepted.
`timescale 1ns / 1ps

module merge_sorter #(
   parameter int MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  msort_pkg::req_beat_type req_beat,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output msort_pkg::rsp_beat_type rsp_beat
);

   msort_pkg::cmd_type    cmd;
   msort_pkg::status_type status;

   msort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_final (req_beat.final_item),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   msort_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_beat.value),
      .cmd       (cmd),
      .status    (status),
      .rsp_beat  (rsp_beat)
   );

endmodule

// ----- sv/msort_chk.sv -----
// Port-level checker for the merge sorter, bound to the top level.
`timescale 1ns / 1ps

module msort_chk (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input msort_pkg::req_beat_type req_beat,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input msort_pkg::rsp_beat_type rsp_beat
);

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beat))
      else $error("result beat changed while stalled");

   // Loading and emitting never overlap.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   // The block comes out of reset ready for a new list.
   assert property (@(posedge clock) $fell(reset) |-> req_ready && !rsp_valid)
      else $error("not ready after reset");

   // The final result returns the block to loading.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_beat.final_result |=> req_ready && !rsp_valid)
      else $error("not ready after final result");

   // Within a run, no input is taken between results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_beat.final_result |=> !req_ready)
      else $error("input taken in the middle of a run");

endmodule

bind merge_sorter msort_chk u_msort_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_beat  (req_beat),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_beat  (rsp_beat)
);

// ----- dv/merge_sorter_checker.sv -----
// Checker for the merge sorter: predicts each sorted run from the request beats and compares.
`timescale 1ns / 1ps

module merge_sorter_checker #(
   parameter int MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  msort_pkg::req_beat_type req_beat,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  msort_pkg::rsp_beat_type rsp_beat,
   output int unsigned             mismatch_count,
   output int unsigned             results_owed
);

   logic signed [msort_pkg::DATA_W-1:0] kept_elems[$];
   logic                                elems_dropped;
   msort_pkg::rsp_beat_type             sorted_results[$];

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
      elems_dropped  = 1'b0;
   end

   task automatic flag_mismatch(input string what, input msort_pkg::rsp_beat_type want,
                                input msort_pkg::rsp_beat_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%t: %s: expected %0d final %0b ovf %0b, got %0d final %0b ovf %0b",
                  $realtime, what, want.sorted_value, want.final_result, want.overflowed,
                  got.sorted_value, got.final_result, got.overflowed);
      end
   endtask

   always @(posedge clock) begin : track
      logic signed [msort_pkg::DATA_W-1:0] key;
      msort_pkg::rsp_beat_type             want;
      int                                  j;
      if (reset) begin
         kept_elems.delete();
         sorted_results.delete();
         elems_dropped = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (kept_elems.size() < MAX_ITEMS) begin
               kept_elems = {kept_elems, req_beat.value};
            end else begin
               elems_dropped = 1'b1;
            end
            if (req_beat.final_item) begin
               // Insertion sort moves an element only past strictly greater ones,
               // so equal values keep their arrival order.
               for (int i = 1; i < kept_elems.size(); i++) begin
                  key = kept_elems[i];
                  j   = i;
                  while (j > 0 && kept_elems[j-1] > key) begin
                     kept_elems[j] = kept_elems[j-1];
                     j--;
                  end
                  kept_elems[j] = key;
               end
               foreach (kept_elems[k]) begin
                  want.sorted_value = kept_elems[k];
                  want.final_result = (k == kept_elems.size() - 1);
                  want.overflowed   = elems_dropped;
                  sorted_results    = {sorted_results, want};
               end
               kept_elems.delete();
               elems_dropped = 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (sorted_results.size() == 0) begin
               flag_mismatch("result beat with nothing expected", '0, rsp_beat);
            end else begin
               want = sorted_results.pop_front();
               if (rsp_beat.sorted_value !== want.sorted_value ||
                   rsp_beat.final_result !== want.final_result ||
                   rsp_beat.overflowed !== want.overflowed) begin
                  flag_mismatch("result beat differs", want, rsp_beat);
               end
            end
         end
      end
      results_owed = sorted_results.size();
   end

endmodule

// ----- dv/merge_sorter_tb.sv -----
// Testbench top for the merge sorter: drives lists of values and gives the verdict.
`timescale 1ns / 1ps

module merge_sorter_tb;

   localparam int PHASE_ITEMS = 100;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   msort_pkg::req_beat_type req_beat = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   msort_pkg::rsp_beat_type rsp_beat;

   int unsigned  mismatch_count;
   int unsigned  results_owed;
   int unsigned  gap_pct = 0;
   int unsigned  stall_pct = 0;
   int unsigned  phase_sent;

   logic signed [msort_pkg::DATA_W-1:0] list_q[$];

   merge_sorter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   merge_sorter_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_beat       (req_beat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_beat       (rsp_beat),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Sends list_q as one sequence, with the final marker on its last beat.
   // Called at a falling edge and returns at a falling edge.
   task automatic send_list();
      foreach (list_q[i]) begin
         while ($urandom_range(99) < gap_pct) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid           <= 1'b1;
         req_beat.value      <= list_q[i];
         req_beat.final_item <= (i == list_q.size() - 1);
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
      end
      phase_sent += list_q.size();
   endtask

   initial begin
      int unsigned pick;
      int unsigned len;
      logic signed [msort_pkg::DATA_W-1:0] elem;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A single element at each extreme of the range.
      list_q = '{32'sh80000000};
      send_list();
      list_q = '{32'sh7fffffff};
      send_list();
      // Both extremes, zero and neighbors, with repeated extremes.
      list_q = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh7fffffff, 32'sh80000000};
      send_list();
      list_q = '{3, -3, 3, 3, -3, 0};
      send_list();
      list_q = '{-2, -1, 0, 1};
      send_list();
      list_q = '{4, 3, 2, 1};
      send_list();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 50; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 50; end
            default: begin gap_pct = 34; stall_pct = 34; end
         endcase
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
               len = $urandom_range(12, 1);
            end else if (pick < 92) begin
               len = $urandom_range(63, 13);
            end else begin
               // Full store, and lists long enough to drop beats, final one too.
               len = $urandom_range(70, 64);
            end
            list_q.delete();
            repeat (len) begin
               case ($urandom_range(9))
                  6, 7:    elem = $signed($urandom_range(8)) - 4;
                  8:       elem = 32'sh80000000 + $urandom_range(3);
                  9:       elem = 32'sh7fffffff - $urandom_range(3);
                  default: elem = $urandom;
               endcase
               list_q = {list_q, elem};
            end
            send_list();
         end
         // Hold the sender off until the block has drained.
         req_valid <= 1'b0;
         while (results_owed != 0) @(negedge clock);
      end

      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
